// ===== design/sctok_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctok_pkg
// Types, codes and constants shared by the command-line tokenizer files.
// ----------------------------------------------------------------------------
package sctok_pkg;

  localparam int CharW  = 8;
  localparam int CountW = 8;
  localparam int TotalW = 9;
  localparam int CfgIndexW = 8;

  localparam logic [CountW-1:0] COUNT_MAX = 8'hFF;
  localparam logic [TotalW-1:0] TOTAL_MAX = 9'h1FF;
  localparam logic [7:0] LIMIT_RESET = 8'hFF;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] REG_MAX_TOKEN_CHARS  = 8'd0;
  localparam logic [CfgIndexW-1:0] REG_MAX_TOTAL_TOKENS = 8'd1;

  // Characters with a meaning of their own.
  localparam logic [CharW-1:0] CH_SPACE   = 8'h20;
  localparam logic [CharW-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CharW-1:0] CH_TAB     = 8'h09;
  localparam logic [CharW-1:0] CH_PIPE    = 8'h7C;
  localparam logic [CharW-1:0] CH_LESS    = 8'h3C;
  localparam logic [CharW-1:0] CH_GREATER = 8'h3E;

  // Byte roles.
  localparam logic [2:0] ROLE_SEPARATOR = 3'd0;
  localparam logic [2:0] ROLE_ARG_CHAR  = 3'd1;
  localparam logic [2:0] ROLE_REDIR_IN  = 3'd2;
  localparam logic [2:0] ROLE_REDIR_OUT = 3'd3;
  localparam logic [2:0] ROLE_FILE_CHAR = 3'd4;
  localparam logic [2:0] ROLE_PIPE      = 3'd5;
  localparam logic [2:0] ROLE_IGNORED   = 3'd6;

  // Token closed just before a byte.
  localparam logic [1:0] CLOSED_NONE = 2'd0;
  localparam logic [1:0] CLOSED_ARG  = 2'd1;
  localparam logic [1:0] CLOSED_FILE = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_LEADING_PIPE = 3'd1;
  localparam logic [2:0] ERR_EMPTY_CMD    = 3'd2;
  localparam logic [2:0] ERR_NO_FILENAME  = 3'd3;
  localparam logic [2:0] ERR_ARG_LONG     = 3'd4;
  localparam logic [2:0] ERR_FILE_LONG    = 3'd5;
  localparam logic [2:0] ERR_TOO_MANY     = 3'd6;

  typedef enum logic [1:0] {
    MODE_BETWEEN,
    MODE_ARG,
    MODE_REDIR_WAIT,
    MODE_FILE
  } mode_t;

  typedef struct packed {
    logic [CharW-1:0] char_in;
    logic             end_of_line;
  } in_beat_t;

  typedef struct packed {
    logic [CharW-1:0]  char_out;
    logic [2:0]        role;
    logic [1:0]        closed_token;
    logic [CountW-1:0] command_number;
    logic [CountW-1:0] argument_number;
    logic [2:0]        error_code;
    logic              line_done;
  } out_beat_t;

  typedef struct packed {
    mode_t             parse_mode;
    logic [7:0]        token_length;
    logic [TotalW-1:0] token_total;
    logic [CountW-1:0] command_count;
    logic [CountW-1:0] argument_count;
    logic              command_has_content;
    logic [2:0]        sticky_error;
  } tok_state_t;

  localparam tok_state_t TOK_STATE_RESET = '{
    parse_mode:          MODE_BETWEEN,
    token_length:        8'd0,
    token_total:         9'd0,
    command_count:       8'd0,
    argument_count:      8'd0,
    command_has_content: 1'b0,
    sticky_error:        ERR_NONE
  };

endpackage

// ===== design/shell_command_line_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_command_line_tokenizer
// Streaming tokenizer for shell command lines, one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_beat) carries one byte of the
//   command line per beat, with end_of_line set on the last byte. Each input
//   beat yields exactly one result beat on the output channel (out_valid,
//   out_stall, out_beat): the byte echoed with its role, the token closed
//   before it, its command and argument numbers, the sticky error code of
//   the line and the line_done flag.
//   A byte accepted at a clock edge shows its result in the output register
//   right after that edge. Throughput is one byte per cycle while the
//   receiver does not stall; the bound is the update of the line state,
//   which feeds back into the next byte's classification.
//   The result sits in an output register. The block keeps taking bytes as
//   long as that register is empty or being emptied in the same cycle; while
//   the receiver stalls a waiting result, in_stall is raised and the result
//   holds.
//   The configuration port (cfg_valid, cfg_ready, cfg_index, cfg_data) sets
//   the token length limit (index 0) and the token total limit (index 1). It
//   is always ready; writes to other indexes are dropped.
//   Synchronous reset returns both limits to 255, clears the line state and
//   empties the output register.
// ----------------------------------------------------------------------------
module shell_command_line_tokenizer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sctok_pkg::in_beat_t                 in_beat,
  output logic                                out_valid,
  input  logic                                out_stall,
  output sctok_pkg::out_beat_t                out_beat,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sctok_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [7:0]                          cfg_data
);
  import sctok_pkg::*;

  logic [7:0] max_token_chars;
  logic [7:0] max_total_tokens;
  tok_state_t state;
  tok_state_t state_next;
  out_beat_t  result;
  logic       accept;

  // A new byte may enter whenever the output register is free or is being
  // read out in this cycle.
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  sctok_step u_step (
    .cur       (state),
    .beat      (in_beat),
    .lim_chars (max_token_chars),
    .lim_total (max_total_tokens),
    .nxt       (state_next),
    .res       (result)
  );

  // Limits and line state. Configuration must only change while the block is
  // idle, so no write races with a byte in flight; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_token_chars  <= LIMIT_RESET;
      max_total_tokens <= LIMIT_RESET;
      state            <= TOK_STATE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAX_TOKEN_CHARS) begin
          max_token_chars <= cfg_data;
        end else if (cfg_index == REG_MAX_TOTAL_TOKENS) begin
          max_total_tokens <= cfg_data;
        end
      end
      if (accept) begin
        state <= state_next;
      end
    end
  end

  // Output register: filled on every accepted byte, emptied when the
  // receiver takes the beat and nothing new arrives.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_beat <= result;
    end
  end

endmodule

// ===== design/sctok_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctok_step
// Classifies one byte against the current line state and forms the next
// line state and the result beat.
// ----------------------------------------------------------------------------
module sctok_step (
  input  sctok_pkg::tok_state_t cur,
  input  sctok_pkg::in_beat_t   beat,
  input  logic [7:0]            lim_chars,
  input  logic [7:0]            lim_total,
  output sctok_pkg::tok_state_t nxt,
  output sctok_pkg::out_beat_t  res
);
  import sctok_pkg::*;

  function automatic logic [TotalW-1:0] total_add(input logic [TotalW-1:0] t,
                                                  input logic [1:0] n);
    logic [TotalW:0] sum;
    sum = {1'b0, t} + {{(TotalW-1){1'b0}}, n};
    return (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TotalW-1:0];
  endfunction

  // Closing an argument counts it, unless the token total is already at the
  // limit, in which case the line fails instead.
  function automatic tok_state_t close_arg(input tok_state_t s,
                                           input logic [7:0] lim);
    tok_state_t r;
    r = s;
    if (s.token_length != 8'd0) begin
      if (s.token_total >= {1'b0, lim}) begin
        r.sticky_error = ERR_TOO_MANY;
      end else begin
        if (s.argument_count < COUNT_MAX) begin
          r.argument_count = s.argument_count + 8'd1;
        end
        r.token_total  = total_add(s.token_total, 2'd1);
        r.token_length = 8'd0;
      end
    end
    return r;
  endfunction

  logic              is_sep, is_pipe, is_angle, is_break;
  tok_state_t        work;
  logic [2:0]        role;
  logic [1:0]        closed;
  logic [CountW-1:0] cnum, anum;

  assign is_sep   = (beat.char_in == CH_SPACE) || (beat.char_in == CH_NEWLINE) ||
                    (beat.char_in == CH_TAB);
  assign is_pipe  = (beat.char_in == CH_PIPE);
  assign is_angle = (beat.char_in == CH_LESS) || (beat.char_in == CH_GREATER);
  assign is_break = is_sep || is_pipe || is_angle;

  // Line state update for this byte.
  always_comb begin
    work   = cur;
    role   = ROLE_IGNORED;
    closed = CLOSED_NONE;
    cnum   = cur.command_count;
    anum   = cur.argument_count;
    if (cur.sticky_error == ERR_NONE) begin
      if (cur.parse_mode == MODE_ARG && is_break) begin
        work = close_arg(cur, lim_total);
        if (work.sticky_error == ERR_NONE) begin
          closed = CLOSED_ARG;
        end
        work.parse_mode = MODE_BETWEEN;
      end else if (cur.parse_mode == MODE_FILE && is_break) begin
        work.token_length = 8'd0;
        closed            = CLOSED_FILE;
        work.parse_mode   = MODE_BETWEEN;
      end
      cnum = work.command_count;
      anum = work.argument_count;

      if (work.sticky_error == ERR_NONE) begin
        priority if (work.parse_mode == MODE_REDIR_WAIT && is_sep) begin
          role = ROLE_SEPARATOR;
        end else if (work.parse_mode == MODE_REDIR_WAIT ||
                     work.parse_mode == MODE_FILE) begin
          // Whatever follows a redirection, separators apart, is taken as a file name byte.
          if (work.token_length >= lim_chars) begin
            work.sticky_error = ERR_FILE_LONG;
          end else begin
            work.token_length = work.token_length + 8'd1;
            role              = ROLE_FILE_CHAR;
            work.parse_mode   = MODE_FILE;
          end
        end else if (work.parse_mode == MODE_ARG) begin
          if (work.token_length >= lim_chars) begin
            work.sticky_error = ERR_ARG_LONG;
          end else begin
            work.token_length = work.token_length + 8'd1;
            role              = ROLE_ARG_CHAR;
          end
        end else if (is_sep) begin
          role = ROLE_SEPARATOR;
        end else if (is_pipe) begin
          if (!work.command_has_content) begin
            work.sticky_error = (work.command_count == 8'd0) ? ERR_LEADING_PIPE
                                                             : ERR_EMPTY_CMD;
          end else begin
            role = ROLE_PIPE;
            if (work.command_count < COUNT_MAX) begin
              work.command_count = work.command_count + 8'd1;
            end
            work.argument_count      = 8'd0;
            work.command_has_content = 1'b0;
            work.token_total         = total_add(work.token_total, 2'd1);
          end
        end else if (is_angle) begin
          role = (beat.char_in == CH_LESS) ? ROLE_REDIR_IN : ROLE_REDIR_OUT;
          work.command_has_content = 1'b1;
          work.token_total         = total_add(work.token_total, 2'd2);
          work.parse_mode          = MODE_REDIR_WAIT;
        end else begin
          if (work.token_length >= lim_chars) begin
            work.sticky_error = ERR_ARG_LONG;
          end else begin
            work.token_length        = work.token_length + 8'd1;
            role                     = ROLE_ARG_CHAR;
            work.command_has_content = 1'b1;
            work.parse_mode          = MODE_ARG;
          end
        end
      end

      // End of line: close an open argument, check for a dangling
      // redirection and for an empty final command.
      if (beat.end_of_line && work.sticky_error == ERR_NONE) begin
        if (work.parse_mode == MODE_ARG) begin
          work = close_arg(work, lim_total);
        end else if (work.parse_mode == MODE_REDIR_WAIT) begin
          work.sticky_error = ERR_NO_FILENAME;
        end
        if (work.sticky_error == ERR_NONE && work.command_count != 8'd0 &&
            !work.command_has_content) begin
          work.sticky_error = ERR_EMPTY_CMD;
        end
      end
    end
  end

  // The line starts afresh after its last byte.
  always_comb begin
    nxt = beat.end_of_line ? TOK_STATE_RESET : work;
  end

  always_comb begin
    res.char_out        = beat.char_in;
    res.role            = role;
    res.closed_token    = closed;
    res.command_number  = cnum;
    res.argument_number = anum;
    res.error_code      = work.sticky_error;
    res.line_done       = beat.end_of_line;
  end

endmodule

// ===== design/sctok_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctok_checker
// Port-level checks on the tokenizer's channels, bound to the top level.
// ----------------------------------------------------------------------------
module sctok_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input sctok_pkg::in_beat_t  in_beat,
  input logic                 out_valid,
  input logic                 out_stall,
  input sctok_pkg::out_beat_t out_beat
);

  // Reset leaves no result beat pending.
  a_reset_empty : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat pending after reset");

  // Every accepted byte shows its result in the next cycle.
  a_one_cycle : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted byte produced no result beat");

  // The result echoes the byte and its end-of-line flag.
  a_echo : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=>
      (out_beat.char_out == $past(in_beat.char_in)) &&
      (out_beat.line_done == $past(in_beat.end_of_line)))
    else $error("result beat does not match the accepted byte");

  // A stalled result beat holds.
  a_hold : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_beat)))
    else $error("stalled result beat changed");

endmodule

bind shell_command_line_tokenizer sctok_checker u_sctok_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_beat   (in_beat),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_beat  (out_beat)
);
